// ===== sv/markup_entity_decoder_assert.svh =====
// Assertion macros for the markup entity decoder.
`ifndef MARKUP_ENTITY_DECODER_ASSERT_SVH
`define MARKUP_ENTITY_DECODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MKD_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("markup entity decoder: assertion failed");
`define MKD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("markup entity decoder: assertion failed");
`else
`define MKD_ASSERT_IMPL(label, ante, cons)
`define MKD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/mkd_pkg.sv =====
package mkd_pkg;

   localparam logic [7:0] CH_AMP  = 8'h26;
   localparam logic [7:0] CH_SEMI = 8'h3B;

   localparam logic [7:0] UTF_LEAD  = 8'hE2;
   localparam logic [7:0] UTF_MID   = 8'h80;
   localparam logic [7:0] UTF_LDQUO = 8'h9C;
   localparam logic [7:0] UTF_RDQUO = 8'h9D;
   localparam logic [7:0] UTF_EMDASH = 8'h94;

   localparam logic [39:0] NAME_LDQUO  = 40'h6C_64_71_75_6F;
   localparam logic [39:0] NAME_RDQUO  = 40'h72_64_71_75_6F;
   localparam logic [47:0] NAME_EMDASH = 48'h65_6D_64_61_73_68;

   typedef enum logic [1:0] {
      CMD_PASS,
      CMD_ENTITY,
      CMD_ERROR,
      CMD_FLUSH
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
      logic         last;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       unknown_markup;
   } rsp_type;

endpackage

// ===== sv/mkd_front.sv =====
module mkd_front #(
   parameter int MAX_TAG = 8,
   parameter int LEN_W = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      take,
   input  mkd_pkg::req_type          req_data,
   output logic                      push,
   output mkd_pkg::cmd_type          cmd,
   output logic [LEN_W-1:0]          flush_len,
   output logic [MAX_TAG-1:0][7:0]   flush_tags
);

   localparam int IDX_W = $clog2(MAX_TAG);

   logic                    in_tag_ff, in_tag_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic                    ovf_ff, ovf_in;
   logic [MAX_TAG-1:0][7:0] tag_ff, tag_in;
   logic [LEN_W-1:0]        len_grow;
   logic [39:0]             head5;
   logic [47:0]             head6;
   logic                    hit_l, hit_r, hit_e;

   assign head5 = {tag_ff[0], tag_ff[1], tag_ff[2], tag_ff[3], tag_ff[4]};
   assign head6 = {head5, tag_ff[5]};
   assign hit_l = (len_ff == LEN_W'(5)) && (head5 == mkd_pkg::NAME_LDQUO);
   assign hit_r = (len_ff == LEN_W'(5)) && (head5 == mkd_pkg::NAME_RDQUO);
   assign hit_e = (len_ff == LEN_W'(6)) && (head6 == mkd_pkg::NAME_EMDASH);

   always_comb begin
      in_tag_in = in_tag_ff;
      len_in    = len_ff;
      ovf_in    = ovf_ff;
      tag_in    = tag_ff;
      len_grow  = len_ff;
      push      = 1'b0;
      cmd.kind  = mkd_pkg::CMD_PASS;
      cmd.data  = req_data.in_byte;
      cmd.last  = req_data.in_last;
      if (take) begin
         if (!in_tag_ff) begin
            if (req_data.in_byte == mkd_pkg::CH_AMP && !req_data.in_last) begin
               in_tag_in = 1'b1;
               len_in    = '0;
               ovf_in    = 1'b0;
            end else begin
               push = 1'b1;
            end
         end else if (req_data.in_byte == mkd_pkg::CH_SEMI) begin
            push = 1'b1;
            if (ovf_ff || !(hit_l || hit_r || hit_e)) begin
               cmd.kind = mkd_pkg::CMD_ERROR;
               cmd.data = 8'h00;
            end else begin
               cmd.kind = mkd_pkg::CMD_ENTITY;
               cmd.data = hit_l ? mkd_pkg::UTF_LDQUO :
                          hit_r ? mkd_pkg::UTF_RDQUO : mkd_pkg::UTF_EMDASH;
            end
            in_tag_in = 1'b0;
            len_in    = '0;
            ovf_in    = 1'b0;
         end else begin
            if (len_ff < LEN_W'(MAX_TAG)) begin
               tag_in[len_ff[IDX_W-1:0]] = req_data.in_byte;
               len_grow = len_ff + LEN_W'(1);
            end else begin
               ovf_in = 1'b1;
            end
            len_in = len_grow;
            if (req_data.in_last) begin
               push      = 1'b1;
               cmd.kind  = mkd_pkg::CMD_FLUSH;
               in_tag_in = 1'b0;
               len_in    = '0;
               ovf_in    = 1'b0;
            end
         end
      end
   end

   assign flush_len  = len_grow;
   assign flush_tags = tag_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_tag_ff <= 1'b0;
         len_ff    <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         in_tag_ff <= in_tag_in;
         len_ff    <= len_in;
         ovf_ff    <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
   end

endmodule

// ===== sv/mkd_queue.sv =====
module mkd_queue #(
   parameter int W = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [W-1:0]          wr_data,
   input  logic                  pop,
   output logic [W-1:0]          rd_data,
   output mkd_pkg::q_status_type status
);

   logic [W-1:0] mem [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         do_push, do_pop;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;
   assign rd_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== sv/mkd_back.sv =====
module mkd_back #(
   parameter int MAX_TAG = 8,
   parameter int LEN_W = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  mkd_pkg::cmd_type        head_cmd,
   input  logic [LEN_W-1:0]        head_len,
   input  logic [MAX_TAG-1:0][7:0] head_tags,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output mkd_pkg::rsp_type        rsp_data
);

   localparam int IDX_W = $clog2(MAX_TAG);

   logic             rsp_valid_ff, rsp_valid_in;
   mkd_pkg::rsp_type rsp_ff, rsp_in;
   logic [LEN_W-1:0] step_ff, step_in;
   logic [LEN_W-1:0] tag_pos;
   logic             load, fin;
   mkd_pkg::rsp_type cur;

   assign load    = !rsp_valid_ff || rsp_ready;
   assign tag_pos = step_ff - LEN_W'(1);

   always_comb begin
      cur.out_byte       = head_cmd.data;
      cur.out_last       = head_cmd.last;
      cur.unknown_markup = 1'b0;
      fin                = 1'b1;
      case (head_cmd.kind)
         mkd_pkg::CMD_PASS: begin
            fin = 1'b1;
         end
         mkd_pkg::CMD_ERROR: begin
            cur.out_byte       = 8'h00;
            cur.unknown_markup = 1'b1;
         end
         mkd_pkg::CMD_ENTITY: begin
            fin = (step_ff == LEN_W'(2));
            cur.out_last = head_cmd.last && fin;
            if (step_ff == LEN_W'(0)) begin
               cur.out_byte = mkd_pkg::UTF_LEAD;
            end else if (step_ff == LEN_W'(1)) begin
               cur.out_byte = mkd_pkg::UTF_MID;
            end
         end
         mkd_pkg::CMD_FLUSH: begin
            fin = (step_ff == head_len);
            cur.out_last = fin;
            cur.out_byte = (step_ff == LEN_W'(0)) ? mkd_pkg::CH_AMP
                                                  : head_tags[tag_pos[IDX_W-1:0]];
         end
         default: begin
            fin = 1'b1;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      step_in      = step_ff;
      pop          = 1'b0;
      if (load) begin
         rsp_valid_in = head_valid;
         if (head_valid) begin
            rsp_in = cur;
            if (fin) begin
               pop     = 1'b1;
               step_in = '0;
            end else begin
               step_in = step_ff + LEN_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/markup_entity_decoder.sv =====
// Throughput: one input byte per cycle while the command queue is not full; an
// entity gives three results and an unterminated tag at end of string gives one
// plus its stored length, paced by the output register, with a two-entry command
// queue absorbing the difference.
// Reset: synchronous, clears tag mode, queue and output valid; no clearing pass.
`include "markup_entity_decoder_assert.svh"

module markup_entity_decoder #(
   parameter int MAX_TAG = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mkd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mkd_pkg::rsp_type rsp_data
);

   localparam int LEN_W = $clog2(MAX_TAG + 1);
   localparam int CMD_W = $bits(mkd_pkg::cmd_type);
   localparam int Q_W   = CMD_W + LEN_W + 8 * MAX_TAG;

   logic                    take, push, pop;
   mkd_pkg::cmd_type        f_cmd, h_cmd;
   logic [LEN_W-1:0]        f_len, h_len;
   logic [MAX_TAG-1:0][7:0] f_tags, h_tags;
   logic [Q_W-1:0]          q_wr, q_rd;
   mkd_pkg::q_status_type   q_stat;

   assign req_ready = !q_stat.full;
   assign take      = req_valid && req_ready;
   assign q_wr      = {f_cmd, f_len, f_tags};
   assign {h_cmd, h_len, h_tags} = q_rd;

   mkd_front #(
      .MAX_TAG (MAX_TAG),
      .LEN_W   (LEN_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .req_data   (req_data),
      .push       (push),
      .cmd        (f_cmd),
      .flush_len  (f_len),
      .flush_tags (f_tags)
   );

   mkd_queue #(
      .W (Q_W)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (q_wr),
      .pop     (pop),
      .rd_data (q_rd),
      .status  (q_stat)
   );

   mkd_back #(
      .MAX_TAG (MAX_TAG),
      .LEN_W   (LEN_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!q_stat.empty),
      .head_cmd   (h_cmd),
      .head_len   (h_len),
      .head_tags  (h_tags),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   `MKD_ASSERT_IMPL(a_err_zero, rsp_valid && rsp_data.unknown_markup, rsp_data.out_byte == 8'h00)
   `MKD_ASSERT_IMPL(a_q_sane, 1'b1, !(q_stat.full && q_stat.empty))
   `MKD_ASSERT_NEXT(a_reset_idle, reset, !rsp_valid && req_ready)

endmodule

// ===== test/markup_entity_decoder_tb.sv =====
module markup_entity_decoder_tb;

   localparam int TAG_DEPTH = 8;
   localparam int LONG_HOLD = 300;

   typedef enum int {
      ENT_LDQUO,
      ENT_RDQUO,
      ENT_EMDASH,
      ENT_NONE
   } entity_kind_type;

   typedef enum int {
      SEG_TEXT,
      SEG_ENTITY,
      SEG_UNKNOWN,
      SEG_CORRUPT,
      SEG_OPEN,
      SEG_NOISE
   } segment_kind_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   mkd_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   mkd_pkg::rsp_type rsp_data;

   // decoder state as predicted
   bit         in_markup = 1'b0;
   logic [7:0] tag_buf [TAG_DEPTH];
   int         tag_count = 0;
   bit         tag_spilled = 1'b0;

   mkd_pkg::rsp_type expected_out [$];
   mkd_pkg::rsp_type want_rsp;
   logic [7:0]       line_buf [$];

   int items_sent = 0;
   int error_count = 0;
   bit idle_on = 1'b1;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;
   int stall_left = 0;

   markup_entity_decoder #(.MAX_TAG(TAG_DEPTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   function automatic int entity_size(entity_kind_type e);
      return (e == ENT_EMDASH) ? 6 : 5;
   endfunction

   function automatic logic [7:0] entity_char(entity_kind_type e, int i);
      case (e)
         ENT_LDQUO:  return mkd_pkg::NAME_LDQUO[39 - 8 * i -: 8];
         ENT_RDQUO:  return mkd_pkg::NAME_RDQUO[39 - 8 * i -: 8];
         ENT_EMDASH: return mkd_pkg::NAME_EMDASH[47 - 8 * i -: 8];
         default:    return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] entity_code(entity_kind_type e);
      case (e)
         ENT_LDQUO: return mkd_pkg::UTF_LDQUO;
         ENT_RDQUO: return mkd_pkg::UTF_RDQUO;
         default:   return mkd_pkg::UTF_EMDASH;
      endcase
   endfunction

   function automatic entity_kind_type match_entity();
      entity_kind_type cands [3];
      bit              same;
      cands = '{ENT_LDQUO, ENT_RDQUO, ENT_EMDASH};
      foreach (cands[k]) begin
         if (tag_count == entity_size(cands[k])) begin
            same = 1'b1;
            for (int i = 0; i < tag_count; i++) begin
               if (tag_buf[i] != entity_char(cands[k], i)) same = 1'b0;
            end
            if (same) return cands[k];
         end
      end
      return ENT_NONE;
   endfunction

   function automatic void push_result(logic [7:0] b, logic fin, logic err);
      mkd_pkg::rsp_type r;
      r.out_byte = b;
      r.out_last = fin;
      r.unknown_markup = err;
      expected_out.insert(expected_out.size(), r);
   endfunction

   function automatic void predict_decode(mkd_pkg::req_type item);
      logic [7:0]      b;
      logic            fin;
      entity_kind_type ent;
      b = item.in_byte;
      fin = item.in_last;
      if (!in_markup) begin
         if (b == mkd_pkg::CH_AMP && fin) begin
            push_result(mkd_pkg::CH_AMP, 1'b1, 1'b0);
         end else if (b == mkd_pkg::CH_AMP) begin
            in_markup = 1'b1;
            tag_count = 0;
            tag_spilled = 1'b0;
         end else begin
            push_result(b, fin, 1'b0);
         end
      end else if (b == mkd_pkg::CH_SEMI) begin
         ent = tag_spilled ? ENT_NONE : match_entity();
         if (ent == ENT_NONE) begin
            push_result(8'h00, fin, 1'b1);
         end else begin
            push_result(mkd_pkg::UTF_LEAD, 1'b0, 1'b0);
            push_result(mkd_pkg::UTF_MID, 1'b0, 1'b0);
            push_result(entity_code(ent), fin, 1'b0);
         end
         in_markup = 1'b0;
         tag_count = 0;
         tag_spilled = 1'b0;
      end else begin
         if (tag_count < TAG_DEPTH) begin
            tag_buf[tag_count] = b;
            tag_count++;
         end else begin
            tag_spilled = 1'b1;
         end
         if (fin) begin
            push_result(mkd_pkg::CH_AMP, tag_count == 0, 1'b0);
            for (int i = 0; i < tag_count; i++) push_result(tag_buf[i], i + 1 == tag_count, 1'b0);
            in_markup = 1'b0;
            tag_count = 0;
            tag_spilled = 1'b0;
         end
      end
   endfunction

   // result side: random stalls, plus a long hold on request
   always @(posedge clock) begin
      if (holds_served != hold_requests) begin
         holds_served = hold_requests;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_out.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected transfer: byte %h last %b unknown %b",
                        rsp_data.out_byte, rsp_data.out_last, rsp_data.unknown_markup);
         end else begin
            want_rsp = expected_out.pop_front();
            if (rsp_data.out_byte !== want_rsp.out_byte ||
                rsp_data.out_last !== want_rsp.out_last ||
                rsp_data.unknown_markup !== want_rsp.unknown_markup) begin
               error_count++;
               if (error_count <= 10)
                  $display("mismatch: expected %h/%b/%b got %h/%b/%b",
                           want_rsp.out_byte, want_rsp.out_last, want_rsp.unknown_markup,
                           rsp_data.out_byte, rsp_data.out_last, rsp_data.unknown_markup);
            end
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic fin);
      mkd_pkg::req_type item;
      int               gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.in_byte = b;
      item.in_last = fin;
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_decode(item);
      items_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_out.size() != 0) @(posedge clock);
   endtask

   task automatic send_entity(input entity_kind_type e, input logic fin);
      send_byte(mkd_pkg::CH_AMP, 1'b0);
      for (int i = 0; i < entity_size(e); i++) send_byte(entity_char(e, i), 1'b0);
      send_byte(mkd_pkg::CH_SEMI, fin);
   endtask

   task automatic send_string();
      for (int i = 0; i < line_buf.size(); i++) send_byte(line_buf[i], i == line_buf.size() - 1);
   endtask

   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      return (b == mkd_pkg::CH_AMP) ? 8'h7E : b;
   endfunction

   function automatic logic [7:0] tag_char();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      return (b == mkd_pkg::CH_SEMI) ? 8'h3A : b;
   endfunction

   task automatic build_random_string();
      int               segs;
      int               r;
      int               n;
      int               pos;
      segment_kind_type kind;
      entity_kind_type  ent;
      line_buf.delete();
      segs = $urandom_range(1, 5);
      repeat (segs) begin
         r = $urandom_range(0, 9);
         kind = r < 3 ? SEG_TEXT : r < 6 ? SEG_ENTITY : r == 6 ? SEG_UNKNOWN :
                r == 7 ? SEG_CORRUPT : r == 8 ? SEG_OPEN : SEG_NOISE;
         ent = entity_kind_type'($urandom_range(0, 2));
         case (kind)
            SEG_TEXT: begin
               repeat ($urandom_range(1, 4)) line_buf.insert(line_buf.size(), text_byte());
            end
            SEG_ENTITY, SEG_CORRUPT: begin
               pos = (kind == SEG_CORRUPT) ? $urandom_range(0, entity_size(ent) - 1) : -1;
               line_buf.insert(line_buf.size(), mkd_pkg::CH_AMP);
               for (int i = 0; i < entity_size(ent); i++)
                  line_buf.insert(line_buf.size(), i == pos ? tag_char() : entity_char(ent, i));
               line_buf.insert(line_buf.size(), mkd_pkg::CH_SEMI);
            end
            SEG_UNKNOWN: begin
               n = $urandom_range(0, 11);
               line_buf.insert(line_buf.size(), mkd_pkg::CH_AMP);
               repeat (n) line_buf.insert(line_buf.size(), tag_char());
               line_buf.insert(line_buf.size(), mkd_pkg::CH_SEMI);
            end
            SEG_OPEN: begin
               n = $urandom_range(0, entity_size(ent));
               line_buf.insert(line_buf.size(), mkd_pkg::CH_AMP);
               for (int i = 0; i < n; i++) line_buf.insert(line_buf.size(), entity_char(ent, i));
            end
            default: begin
               line_buf.insert(line_buf.size(), 8'($urandom_range(0, 255)));
            end
         endcase
      end
   endtask

   task automatic test_plain_text();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(mkd_pkg::CH_SEMI, 1'b0);
      send_byte(8'h5A, 1'b1);
   endtask

   task automatic test_entities();
      send_entity(ENT_LDQUO, 1'b0);
      send_entity(ENT_RDQUO, 1'b0);
      send_entity(ENT_EMDASH, 1'b1);
   endtask

   task automatic test_bad_tags();
      send_byte(mkd_pkg::CH_AMP, 1'b0);
      send_byte(mkd_pkg::CH_SEMI, 1'b0);
      send_byte(mkd_pkg::CH_AMP, 1'b0);
      send_byte(mkd_pkg::CH_AMP, 1'b0);
      send_byte(8'h78, 1'b0);
      send_byte(mkd_pkg::CH_SEMI, 1'b0);
      send_byte(mkd_pkg::CH_AMP, 1'b0);
      for (int i = 0; i < 6; i++) send_byte(entity_char(ENT_EMDASH, i), 1'b0);
      send_byte(8'h78, 1'b0);
      send_byte(8'h79, 1'b0);
      send_byte(8'h7A, 1'b0);
      send_byte(mkd_pkg::CH_SEMI, 1'b1);
   endtask

   task automatic test_open_tag_at_end();
      send_byte(mkd_pkg::CH_AMP, 1'b1);
      send_byte(mkd_pkg::CH_AMP, 1'b0);
      send_byte(8'h72, 1'b0);
      send_byte(8'h64, 1'b1);
      send_byte(mkd_pkg::CH_AMP, 1'b0);
      for (int i = 0; i < 10; i++) send_byte(8'(8'h61 + i), i == 9);
      send_byte(mkd_pkg::CH_AMP, 1'b0);
      send_byte(mkd_pkg::CH_SEMI, 1'b1);
   endtask

   task automatic test_output_backpressure();
      hold_requests++;
      for (int i = 0; i < 6; i++) send_entity(entity_kind_type'(i % 3), i == 5);
      drain_results();
   endtask

   task automatic test_random_text(input int target);
      while (items_sent < target) begin
         build_random_string();
         send_string();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_plain_text();
      test_entities();
      test_bad_tags();
      test_open_tag_at_end();
      drain_results();
      test_output_backpressure();
      test_random_text(330);
      drain_results();
      idle_on = 1'b0;
      test_random_text(420);
      drain_results();
      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_out.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
